// ===== sv/tslp_pkg.sv =====
// Shared types and constants for the tracker sample line player.
package tslp_pkg;

    localparam int ROWS      = 64;
    localparam int OPCODE_W  = 2;
    localparam int ADDR_W    = 6;
    localparam int POS_W     = 7;
    localparam int ROW_W     = 32;
    localparam int OFFSET_W  = 8;
    localparam int TONE_W    = 16;
    localparam int VOLUME_W  = 5;
    localparam int MASK_W    = 4;
    localparam int SLIDE_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic signed [SLIDE_W-1:0] SLIDE_MAX = 5'sd15;
    localparam logic signed [SLIDE_W-1:0] SLIDE_MIN = -5'sd15;

    // byte0 bits 7:6 slide codes
    localparam logic [1:0] SLIDE_UP   = 2'b11;
    localparam logic [1:0] SLIDE_DOWN = 2'b10;

    // byte1 flag positions
    localparam int B1_NOISE_MASK = 7;
    localparam int B1_TONE_ACC   = 6;
    localparam int B1_OFFS_ACC   = 5;
    localparam int B1_TONE_MASK  = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD     = 2'd1,
        OP_SET_POS  = 2'd2,
        OP_RESTART  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_ROW = 1'd0,
        REG_END_ROW  = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic fire;
        logic restart;
    } step_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] noise_offset;
        logic [OFFSET_W-1:0] envelope_offset;
        logic [TONE_W-1:0]   tone_shift;
        logic [VOLUME_W-1:0] volume;
        logic [MASK_W-1:0]   channel_mask;
    } result_t;

endpackage

// ===== sv/tslp_if.sv =====
// Handshake channel interfaces for input items and result items.
interface tslp_item_if;
    logic                           valid;
    logic                           ready;
    logic [tslp_pkg::OPCODE_W-1:0]  opcode;
    logic [tslp_pkg::ADDR_W-1:0]    row_index;
    logic [tslp_pkg::ROW_W-1:0]     row_data;

    modport source (output valid, opcode, row_index, row_data, input ready);
    modport sink (input valid, opcode, row_index, row_data, output ready);
    modport monitor (input valid, ready, opcode, row_index, row_data);
endinterface

interface tslp_result_if;
    logic                           valid;
    logic                           ready;
    logic [tslp_pkg::OFFSET_W-1:0]  noise_offset;
    logic [tslp_pkg::OFFSET_W-1:0]  envelope_offset;
    logic [tslp_pkg::TONE_W-1:0]    tone_shift;
    logic [tslp_pkg::VOLUME_W-1:0]  volume;
    logic [tslp_pkg::MASK_W-1:0]    channel_mask;

    modport source (output valid, noise_offset, envelope_offset, tone_shift, volume,
                    channel_mask, input ready);
    modport sink (input valid, noise_offset, envelope_offset, tone_shift, volume,
                  channel_mask, output ready);
    modport monitor (input valid, ready, noise_offset, envelope_offset, tone_shift,
                     volume, channel_mask);
endinterface

// ===== sv/tslp_row_play.sv =====
// Row playback: accumulators, volume slide and result computation for one row.
module tslp_row_play (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tslp_pkg::step_t             step,
    input  logic [tslp_pkg::ROW_W-1:0]  row,
    output tslp_pkg::result_t           result
);

    logic [tslp_pkg::OFFSET_W-1:0]      noise_acc_reg, noise_acc_next;
    logic [tslp_pkg::OFFSET_W-1:0]      env_acc_reg, env_acc_next;
    logic [tslp_pkg::TONE_W-1:0]        tone_base_reg, tone_base_next;
    logic signed [tslp_pkg::SLIDE_W-1:0] slide_reg, slide_next, slide_play;

    logic [7:0]                         b0;
    logic [7:0]                         b1;
    logic [tslp_pkg::TONE_W-1:0]        tone;
    logic [tslp_pkg::OFFSET_W-1:0]      offs;
    logic [tslp_pkg::OFFSET_W-1:0]      noise_sum;
    logic [tslp_pkg::OFFSET_W-1:0]      env_sum;
    logic [tslp_pkg::TONE_W-1:0]        tone_sum;
    logic signed [tslp_pkg::SLIDE_W:0]  vol_sum;
    logic [3:0]                         vol_clamped;

    assign b0        = row[7:0];
    assign b1        = row[15:8];
    assign tone      = row[31:16];
    assign offs      = {4'b0000, b0[4:1]};
    assign noise_sum = noise_acc_reg + offs;
    assign env_sum   = env_acc_reg + offs;
    assign tone_sum  = tone_base_reg + tone;

    always_comb
    begin
        slide_play = slide_reg;
        if (b0[7:6] == tslp_pkg::SLIDE_UP && slide_reg < tslp_pkg::SLIDE_MAX)
        begin
            slide_play = slide_reg + 5'sd1;
        end
        else if (b0[7:6] == tslp_pkg::SLIDE_DOWN && slide_reg > tslp_pkg::SLIDE_MIN)
        begin
            slide_play = slide_reg - 5'sd1;
        end
    end

    assign vol_sum = signed'({2'b00, b1[3:0]}) + signed'({slide_play[4], slide_play});

    always_comb
    begin
        if (vol_sum[tslp_pkg::SLIDE_W])
        begin
            vol_clamped = 4'd0;
        end
        else if (vol_sum[4])
        begin
            vol_clamped = 4'd15;
        end
        else
        begin
            vol_clamped = vol_sum[3:0];
        end
    end

    always_comb
    begin
        result.noise_offset    = '0;
        result.envelope_offset = '0;
        if (!b1[tslp_pkg::B1_NOISE_MASK])
        begin
            result.noise_offset = noise_sum;
        end
        else if (!b0[0])
        begin
            result.envelope_offset = env_sum;
        end
        result.tone_shift   = tone_sum;
        result.volume       = {~b0[0], vol_clamped};
        result.channel_mask = {b1[tslp_pkg::B1_NOISE_MASK], 2'b00, b1[tslp_pkg::B1_TONE_MASK]};
    end

    always_comb
    begin
        noise_acc_next = noise_acc_reg;
        env_acc_next   = env_acc_reg;
        tone_base_next = tone_base_reg;
        slide_next     = slide_reg;
        if (step.fire)
        begin
            if (step.restart)
            begin
                noise_acc_next = '0;
                env_acc_next   = '0;
                tone_base_next = '0;
                slide_next     = '0;
            end
            else
            begin
                // envelope still accumulates when both noise and envelope are masked
                if (b1[tslp_pkg::B1_OFFS_ACC])
                begin
                    if (!b1[tslp_pkg::B1_NOISE_MASK])
                    begin
                        noise_acc_next = noise_sum;
                    end
                    else
                    begin
                        env_acc_next = env_sum;
                    end
                end
                if (b1[tslp_pkg::B1_TONE_ACC])
                begin
                    tone_base_next = tone_sum;
                end
                slide_next = slide_play;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_acc_reg <= '0;
            env_acc_reg   <= '0;
            tone_base_reg <= '0;
            slide_reg     <= '0;
        end
        else
        begin
            noise_acc_reg <= noise_acc_next;
            env_acc_reg   <= env_acc_next;
            tone_base_reg <= tone_base_next;
            slide_reg     <= slide_next;
        end
    end

endmodule

// ===== sv/tracker_sample_line_player.sv =====
// Tracker sample line player: row table, play position and result register.
// A tick's result passes through the row read register, then the result register.
// Throughput: one item per cycle; only a stalled result register holds the input side.
// Load, set position and restart give no result; restart clears the accumulators in order.
// Reset clears position, accumulators, slide, config registers and valid flags; the row table is not cleared.
module tracker_sample_line_player (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [tslp_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [tslp_pkg::CFG_DATA_W-1:0]     wr_data,
    tslp_item_if.sink                           item_in,
    tslp_result_if.source                       result_out
);

    logic [tslp_pkg::ROW_W-1:0]     row_mem [tslp_pkg::ROWS];

    logic [tslp_pkg::ADDR_W-1:0]    loop_row_reg;
    logic [tslp_pkg::POS_W-1:0]     end_row_reg;
    logic [tslp_pkg::POS_W-1:0]     position_reg, position_next;
    logic [tslp_pkg::POS_W-1:0]     play_pos;

    logic                           s1_valid_reg;
    logic                           s1_restart_reg;
    logic                           s1_in_range_reg;
    logic [tslp_pkg::ROW_W-1:0]     s1_row_reg;
    logic [tslp_pkg::ROW_W-1:0]     s1_row;

    logic                           out_valid_reg;
    tslp_pkg::result_t              result_reg;
    tslp_pkg::result_t              result;

    tslp_pkg::op_t                  op;
    tslp_pkg::step_t                step;
    logic                           accept;
    logic                           out_free;
    logic                           s1_advance;

    assign op         = tslp_pkg::op_t'(item_in.opcode);
    assign out_free   = !out_valid_reg || result_out.ready;
    assign s1_advance = s1_valid_reg && (s1_restart_reg || out_free);
    assign item_in.ready = !s1_valid_reg || s1_advance;
    assign accept     = item_in.valid && item_in.ready;

    // wrap to the loop row before reading once the end row is reached
    assign play_pos = (position_reg >= end_row_reg) ? {1'b0, loop_row_reg} : position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_row_reg <= '0;
            end_row_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (tslp_pkg::reg_idx_t'(wr_index))
                tslp_pkg::REG_LOOP_ROW: loop_row_reg <= wr_data[tslp_pkg::ADDR_W-1:0];
                tslp_pkg::REG_END_ROW:  end_row_reg  <= wr_data;
                default:                end_row_reg  <= end_row_reg;
            endcase
        end
    end

    always_comb
    begin
        position_next = position_reg;
        if (accept)
        begin
            case (op)
                tslp_pkg::OP_TICK:    position_next = play_pos + 7'd1;
                tslp_pkg::OP_SET_POS: position_next = {1'b0, item_in.row_index};
                tslp_pkg::OP_RESTART: position_next = '0;
                default:              position_next = position_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            s1_restart_reg  <= 1'b0;
            s1_in_range_reg <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            if (accept && (op == tslp_pkg::OP_TICK || op == tslp_pkg::OP_RESTART))
            begin
                s1_valid_reg    <= 1'b1;
                s1_restart_reg  <= (op == tslp_pkg::OP_RESTART);
                s1_in_range_reg <= (play_pos < tslp_pkg::POS_W'(tslp_pkg::ROWS));
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // row table: one write port for loads, one registered read port for ticks
    always_ff @(posedge clk)
    begin
        if (accept && op == tslp_pkg::OP_LOAD &&
            {1'b0, item_in.row_index} < tslp_pkg::POS_W'(tslp_pkg::ROWS))
        begin
            row_mem[item_in.row_index] <= item_in.row_data;
        end
        if (accept && op == tslp_pkg::OP_TICK)
        begin
            s1_row_reg <= row_mem[play_pos[tslp_pkg::ADDR_W-1:0]];
        end
    end

    // rows past the table read as zero
    assign s1_row       = s1_in_range_reg ? s1_row_reg : '0;
    assign step.fire    = s1_advance;
    assign step.restart = s1_restart_reg;

    tslp_row_play u_row_play (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .row    (s1_row),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && !s1_restart_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && !s1_restart_reg)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.noise_offset    = result_reg.noise_offset;
    assign result_out.envelope_offset = result_reg.envelope_offset;
    assign result_out.tone_shift      = result_reg.tone_shift;
    assign result_out.volume          = result_reg.volume;
    assign result_out.channel_mask    = result_reg.channel_mask;

endmodule

// ===== sv/tslp_checker.sv =====
// Port-level checks for the tracker sample line player, bound to the top level.
module tslp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [tslp_pkg::OFFSET_W-1:0]   out_noise_offset,
    input  logic [tslp_pkg::OFFSET_W-1:0]   out_envelope_offset,
    input  logic [tslp_pkg::TONE_W-1:0]     out_tone_shift,
    input  logic [tslp_pkg::VOLUME_W-1:0]   out_volume,
    input  logic [tslp_pkg::MASK_W-1:0]     out_channel_mask
);

    // hold a result until it is transferred
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transfer");

    a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_tone_shift) && $stable(out_volume) &&
            $stable(out_noise_offset) && $stable(out_envelope_offset))
        else $error("result payload changed while stalled");

    // the input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked result");

    a_offsets_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_noise_offset == 8'd0 || out_envelope_offset == 8'd0))
        else $error("noise and envelope offsets both nonzero");

    a_mask_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_channel_mask[2:1] == 2'b00)
        else $error("unused channel mask bits set");

endmodule

bind tracker_sample_line_player tslp_checker u_tslp_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (item_in.valid),
    .in_ready            (item_in.ready),
    .out_valid           (result_out.valid),
    .out_ready           (result_out.ready),
    .out_noise_offset    (result_out.noise_offset),
    .out_envelope_offset (result_out.envelope_offset),
    .out_tone_shift      (result_out.tone_shift),
    .out_volume          (result_out.volume),
    .out_channel_mask    (result_out.channel_mask)
);
